/* design/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* design/mf_pkg.sv */
package mf_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int PIX_W     = 8;
	localparam int COL_W     = 10;
	localparam int ROW_W     = 12;
	localparam int IMG_W_W   = 11;
	localparam int IMG_H_W   = 13;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;

	localparam int ITEM_QUEUE_DEPTH = 4;

	localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic               FULL_RESET   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_FULL_WINDOW  = 2'd2
	} mf_reg_t;

	typedef logic [PIX_W-1:0] pix_t;

	// Classification of one input item, decided by the front end.
	typedef struct packed {
		logic emit_a;     // filtered pixel one row up and one column left
		logic use_med;    // that pixel is interior and takes the median
		logic emit_b;     // right-edge pixel of the row above
		logic emit_c;     // the input itself, first or last row
		logic frame_end;  // bottom-right pixel of the frame
		logic full_win;   // 3x3 median rather than the cross
	} mf_item_flags_t;

	// Up to three results caused by one item, in delivery order a, b, c.
	typedef struct packed {
		logic             emit_a;
		logic             emit_b;
		logic             emit_c;
		logic             frame_end;
		pix_t             pix_a;
		pix_t             pix_b;
		pix_t             pix_c;
		logic [COL_W-1:0] col_a;
		logic [COL_W-1:0] col_c;
		logic [ROW_W-1:0] row_a;
		logic [ROW_W-1:0] row_c;
	} mf_bundle_t;

	typedef struct packed {
		pix_t hi;
		pix_t mid;
		pix_t lo;
	} mf_trio_t;

	function automatic pix_t min2(pix_t a, pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(pix_t a, pix_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
		return min2(min2(a, b), c);
	endfunction

	function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
		return max2(max2(a, b), c);
	endfunction

	function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	function automatic mf_trio_t sort3(pix_t a, pix_t b, pix_t c);
		mf_trio_t t;
		t.lo  = min3(a, b, c);
		t.mid = med3(a, b, c);
		t.hi  = max3(a, b, c);
		return t;
	endfunction

endpackage

/* design/mf_ram.sv */
module mf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = mf_pkg::MAX_WIDTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

/* design/mf_fifo.sv */
module mf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mf_pkg::ITEM_QUEUE_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + NW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end
endmodule

/* design/mf_front.sv */
module mf_front #(
	parameter int MAX_WIDTH  = mf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mf_pkg::MAX_HEIGHT_DEF,
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [mf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mf_pkg::CFG_W-1:0]     cfg_data,
	input  logic                         push,
	input  logic [mf_pkg::PIX_W-1:0]     in_pixel,
	output logic                         full,
	output logic                         item_push,
	output mf_pkg::mf_item_flags_t       item_flags,
	output logic [mf_pkg::PIX_W-1:0]     item_pixel,
	output logic [CW-1:0]                item_col,
	output logic [RW-1:0]                item_row,
	input  logic                         item_full
);
	import mf_pkg::*;

	localparam int WCMP = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
	localparam int HCMP = (RW + 1 > IMG_H_W) ? RW + 1 : IMG_H_W;

	logic [IMG_W_W-1:0] width_q;
	logic [IMG_H_W-1:0] height_q;
	logic               full_win_q;
	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;

	logic [WCMP-1:0] w_ext;
	logic [HCMP-1:0] h_ext;
	logic [CW-1:0]   w_last;
	logic [RW-1:0]   h_last;
	logic [CW-1:0]   c;
	logic [RW-1:0]   r;
	logic            col_end;
	logic            row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_RESET;
			height_q   <= HEIGHT_RESET;
			full_win_q <= FULL_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q    <= cfg_data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT: height_q   <= cfg_data[IMG_H_W-1:0];
				REG_FULL_WINDOW:  full_win_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A size of zero acts as one, and a size above the buffers is cut to them.
	assign w_ext  = WCMP'(width_q);
	assign h_ext  = HCMP'(height_q);
	assign w_last = (width_q == '0) ? '0 :
		(w_ext > WCMP'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) : CW'(w_ext - WCMP'(1));
	assign h_last = (height_q == '0) ? '0 :
		(h_ext > HCMP'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT - 1) : RW'(h_ext - HCMP'(1));

	// Counts beyond a size that shrank mid-frame saturate to the last column or row.
	assign c       = (col_q > w_last) ? w_last : col_q;
	assign r       = (row_q > h_last) ? h_last : row_q;
	assign col_end = (c == w_last);
	assign row_end = (r == h_last);

	assign full       = item_full;
	assign item_push  = push && !item_full;
	assign item_pixel = in_pixel;
	assign item_col   = c;
	assign item_row   = r;

	always_comb begin
		item_flags.emit_a    = (r > RW'(1)) && (c != '0);
		item_flags.use_med   = (c > CW'(1));
		item_flags.emit_b    = (r > RW'(1)) && col_end;
		item_flags.emit_c    = (r == '0) || row_end;
		item_flags.frame_end = col_end && row_end;
		item_flags.full_win  = full_win_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (item_push) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : r + RW'(1);
			end else begin
				col_q <= c + CW'(1);
				row_q <= r;
			end
		end
	end
endmodule

/* design/mf_back.sv */
module mf_back #(
	parameter int MAX_WIDTH  = mf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mf_pkg::MAX_HEIGHT_DEF,
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_pop,
	input  mf_pkg::mf_item_flags_t   item_flags,
	input  logic [mf_pkg::PIX_W-1:0] item_pixel,
	input  logic [CW-1:0]            item_col,
	input  logic [RW-1:0]            item_row,
	output logic                     bnd_valid,
	output mf_pkg::mf_bundle_t       bnd,
	input  logic                     bnd_ready
);
	import mf_pkg::*;

	logic adv;

	// Stage 1: line buffer data arrives.
	logic           v_s1;
	mf_item_flags_t f_s1;
	pix_t           p_s1;
	logic [CW-1:0]  c_s1;
	logic [RW-1:0]  r_s1;
	logic           fwd_s1;
	logic [2*PIX_W-1:0] fwd_data_s1;

	// Stage 2: window snapshot.
	logic           v_s2;
	mf_item_flags_t f_s2;
	pix_t           p_s2;
	logic [CW-1:0]  c_s2;
	logic [RW-1:0]  r_s2;
	pix_t           win_s2 [9];

	// Stage 3: rows sorted.
	logic           v_s3;
	mf_item_flags_t f_s3;
	pix_t           p_s3;
	logic [CW-1:0]  c_s3;
	logic [RW-1:0]  r_s3;
	pix_t           center_s3;
	pix_t           up1_s3;
	mf_trio_t       trio_s3 [3];

	// Stage 4: the three candidates for the median.
	logic           v_s4;
	mf_item_flags_t f_s4;
	pix_t           p_s4;
	logic [CW-1:0]  c_s4;
	logic [RW-1:0]  r_s4;
	pix_t           center_s4;
	pix_t           up1_s4;
	pix_t           lo_s4;
	pix_t           mid_s4;
	pix_t           hi_s4;

	// Stage 5: result bundle.
	logic           v_s5;
	mf_bundle_t     bnd_s5;

	logic [2*PIX_W-1:0] rd_data;
	logic [2*PIX_W-1:0] line_data;
	pix_t               up1;
	pix_t               up2;
	pix_t               window_q [9];
	pix_t               win_new  [9];
	pix_t               sv       [9];
	mf_trio_t           trio     [3];
	logic [COL_W-1:0]   col_c;
	logic [ROW_W-1:0]   row_c;
	mf_bundle_t         bnd_next;

	// The whole pipeline moves together; it halts only while a bundle waits.
	assign adv      = !v_s5 || bnd_ready;
	assign item_pop = adv && item_valid;

	// Each line buffer entry holds the pixel two rows up and the one a row up.
	mf_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk    (clk),
		.wr_en  (adv && v_s1),
		.wr_addr(c_s1),
		.wr_data({up1, p_s1}),
		.rd_en  (adv),
		.rd_addr(item_col),
		.rd_data(rd_data)
	);

	// When the next item reads the entry being written, take the new data directly.
	assign line_data = fwd_s1 ? fwd_data_s1 : rd_data;
	assign up2       = line_data[2*PIX_W-1:PIX_W];
	assign up1       = line_data[PIX_W-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_new[3*i]     = window_q[3*i+1];
			win_new[3*i + 1] = window_q[3*i+2];
			win_new[3*i + 2] = window_q[3*i+2];
		end
		win_new[2] = up2;
		win_new[5] = up1;
		win_new[8] = p_s1;
	end

	// The cross median is the 3x3 median with two zeros and two full-scale pads.
	always_comb begin
		if (f_s2.full_win) begin
			for (int i = 0; i < 9; i++) begin
				sv[i] = win_s2[i];
			end
		end else begin
			sv[0] = win_s2[1];
			sv[1] = win_s2[3];
			sv[2] = win_s2[4];
			sv[3] = win_s2[5];
			sv[4] = win_s2[7];
			sv[5] = '0;
			sv[6] = '0;
			sv[7] = '1;
			sv[8] = '1;
		end
		for (int i = 0; i < 3; i++) begin
			trio[i] = sort3(sv[3*i], sv[3*i+1], sv[3*i+2]);
		end
	end

	assign col_c = COL_W'(c_s4);
	assign row_c = ROW_W'(r_s4);

	always_comb begin
		bnd_next.emit_a    = f_s4.emit_a;
		bnd_next.emit_b    = f_s4.emit_b;
		bnd_next.emit_c    = f_s4.emit_c;
		bnd_next.frame_end = f_s4.frame_end;
		bnd_next.pix_a     = f_s4.use_med ? med3(lo_s4, mid_s4, hi_s4) : center_s4;
		bnd_next.pix_b     = up1_s4;
		bnd_next.pix_c     = p_s4;
		bnd_next.col_a     = col_c - COL_W'(1);
		bnd_next.col_c     = col_c;
		bnd_next.row_a     = row_c - ROW_W'(1);
		bnd_next.row_c     = row_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			fwd_s1   <= 1'b0;
			window_q <= '{default: '0};
		end else if (adv) begin
			v_s1   <= item_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4 && (f_s4.emit_a || f_s4.emit_b || f_s4.emit_c);
			fwd_s1 <= v_s1 && (item_col == c_s1);
			if (v_s1) begin
				window_q <= win_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1        <= item_flags;
			p_s1        <= item_pixel;
			c_s1        <= item_col;
			r_s1        <= item_row;
			fwd_data_s1 <= {up1, p_s1};

			f_s2   <= f_s1;
			p_s2   <= p_s1;
			c_s2   <= c_s1;
			r_s2   <= r_s1;
			win_s2 <= win_new;

			f_s3      <= f_s2;
			p_s3      <= p_s2;
			c_s3      <= c_s2;
			r_s3      <= r_s2;
			center_s3 <= win_s2[4];
			up1_s3    <= win_s2[5];
			trio_s3   <= trio;

			f_s4      <= f_s3;
			p_s4      <= p_s3;
			c_s4      <= c_s3;
			r_s4      <= r_s3;
			center_s4 <= center_s3;
			up1_s4    <= up1_s3;
			lo_s4     <= max3(trio_s3[0].lo, trio_s3[1].lo, trio_s3[2].lo);
			mid_s4    <= med3(trio_s3[0].mid, trio_s3[1].mid, trio_s3[2].mid);
			hi_s4     <= min3(trio_s3[0].hi, trio_s3[1].hi, trio_s3[2].hi);

			bnd_s5 <= bnd_next;
		end
	end

	assign bnd_valid = v_s5;
	assign bnd       = bnd_s5;
endmodule

/* design/mf_out.sv */
module mf_out (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     bnd_valid,
	input  mf_pkg::mf_bundle_t       bnd,
	output logic                     bnd_ready,
	input  logic                     pop,
	output logic                     empty,
	output logic [mf_pkg::PIX_W-1:0] out_pixel,
	output logic [mf_pkg::COL_W-1:0] column,
	output logic [mf_pkg::ROW_W-1:0] row,
	output logic                     run_last,
	output logic                     frame_done
);
	import mf_pkg::*;

	mf_bundle_t bnd_q;
	logic [2:0] mask_q;
	logic [2:0] mask_rest;
	logic       last;
	logic       take;

	// Bits still pending, in order a, b, c from the low end.
	assign mask_rest = mask_q & (mask_q - 3'd1);
	assign empty     = (mask_q == '0);
	assign last      = !empty && (mask_rest == '0);
	assign take      = pop && !empty;
	assign bnd_ready = empty || (take && last);

	// A new bundle is only loaded once the held one is used up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (bnd_ready && bnd_valid) begin
			mask_q <= {bnd.emit_c, bnd.emit_b, bnd.emit_a};
		end else if (take) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (bnd_ready && bnd_valid) begin
			bnd_q <= bnd;
		end
	end

	always_comb begin
		if (mask_q[0]) begin
			out_pixel = bnd_q.pix_a;
			column    = bnd_q.col_a;
			row       = bnd_q.row_a;
		end else if (mask_q[1]) begin
			out_pixel = bnd_q.pix_b;
			column    = bnd_q.col_c;
			row       = bnd_q.row_a;
		end else begin
			out_pixel = bnd_q.pix_c;
			column    = bnd_q.col_c;
			row       = bnd_q.row_c;
		end
		run_last   = last;
		frame_done = last && bnd_q.frame_end;
	end
endmodule

/* design/median_filter_3x3.sv */
// Channel   Handshake          Payload
// input     push / full        in_pixel
// result    empty / pop        out_pixel, column, row, run_last, frame_done
// config    cfg_write          cfg_index, cfg_data
//
// One pixel is accepted per clock while the queue has room; a result reaches the
// ports through the item queue, the back-end pipeline and the output register.
// Results leave one per clock while pop is held, so last-row pixels, most of which
// cause two results, go in slower; the result serializer sets that limit.
// Reset is asynchronous; the line buffers are not cleared and need no sweep.
// A stalled result holds the back pipeline, and input stalls once the queue fills.
module median_filter_3x3 #(
	parameter int MAX_WIDTH  = mf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [mf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mf_pkg::CFG_W-1:0]     cfg_data,
	input  logic                         push,
	output logic                         full,
	input  logic [mf_pkg::PIX_W-1:0]     in_pixel,
	output logic                         empty,
	input  logic                         pop,
	output logic [mf_pkg::PIX_W-1:0]     out_pixel,
	output logic [mf_pkg::COL_W-1:0]     column,
	output logic [mf_pkg::ROW_W-1:0]     row,
	output logic                         run_last,
	output logic                         frame_done
);
	import mf_pkg::*;

	localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int ITEM_W = $bits(mf_item_flags_t) + PIX_W + CW + RW;

	logic           item_push;
	logic           item_full;
	mf_item_flags_t item_flags;
	pix_t           item_pixel;
	logic [CW-1:0]  item_col;
	logic [RW-1:0]  item_row;

	logic           q_empty;
	logic           q_pop;
	logic [ITEM_W-1:0] q_head;
	mf_item_flags_t h_flags;
	pix_t           h_pixel;
	logic [CW-1:0]  h_col;
	logic [RW-1:0]  h_row;

	logic       bnd_valid;
	logic       bnd_ready;
	mf_bundle_t bnd;

	mf_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.in_pixel  (in_pixel),
		.full      (full),
		.item_push (item_push),
		.item_flags(item_flags),
		.item_pixel(item_pixel),
		.item_col  (item_col),
		.item_row  (item_row),
		.item_full (item_full)
	);

	mf_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(ITEM_QUEUE_DEPTH)
	) u_item_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (item_push),
		.wr_data({item_flags, item_pixel, item_col, item_row}),
		.full   (item_full),
		.rd_en  (q_pop),
		.rd_data(q_head),
		.empty  (q_empty)
	);

	assign {h_flags, h_pixel, h_col, h_row} = q_head;

	mf_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(!q_empty),
		.item_pop  (q_pop),
		.item_flags(h_flags),
		.item_pixel(h_pixel),
		.item_col  (h_col),
		.item_row  (h_row),
		.bnd_valid (bnd_valid),
		.bnd       (bnd),
		.bnd_ready (bnd_ready)
	);

	mf_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.bnd_valid (bnd_valid),
		.bnd       (bnd),
		.bnd_ready (bnd_ready),
		.pop       (pop),
		.empty     (empty),
		.out_pixel (out_pixel),
		.column    (column),
		.row       (row),
		.run_last  (run_last),
		.frame_done(frame_done)
	);
endmodule

/* design/mf_checker.sv */
`include "assert_macros.svh"

module mf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  out_pixel,
	input logic [9:0]  column,
	input logic [11:0] row,
	input logic        run_last,
	input logic        frame_done
);
	// The end of a frame is always the last result of its item.
	`ASSERT_SAME(a_frame_done_last, clk, arst_n, !empty && frame_done, run_last)

	// An item's results leave back to back: after a result that is not the last, another waits.
	`ASSERT_NEXT(a_run_continues, clk, arst_n, pop && !empty && !run_last, !empty)

	// A result that is not taken stays on the ports unchanged.
	`ASSERT_NEXT(a_result_holds, clk, arst_n, !empty && !pop, !empty && $stable(out_pixel) && $stable(column) && $stable(row) && $stable(run_last) && $stable(frame_done))
endmodule

bind median_filter_3x3 mf_checker u_mf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.push      (push),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.out_pixel (out_pixel),
	.column    (column),
	.row       (row),
	.run_last  (run_last),
	.frame_done(frame_done)
);
